>>> rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_PPU_ADDR  = 2'd1;
    localparam logic [1:0] OP_CPU_READ  = 2'd2;

    localparam logic [15:0] WR_DEC_MASK = 16'hF000;
    localparam logic [15:0] WR_PRG0     = 16'h8000;
    localparam logic [15:0] WR_MIRROR   = 16'h9000;
    localparam logic [15:0] WR_PRG1     = 16'hA000;
    localparam logic [15:0] WR_CHR_B    = 16'hB000;
    localparam logic [15:0] WR_CHR_C    = 16'hC000;
    localparam logic [15:0] WR_CHR_D    = 16'hD000;
    localparam logic [15:0] WR_CHR_E    = 16'hE000;
    localparam logic [3:0]  CHR_BASE_NIB = 4'hB;

    localparam logic [15:0] IRQ_DEC_MASK  = 16'hC00C;
    localparam logic [15:0] IRQ_ONESCREEN = 16'h8004;
    localparam logic [15:0] IRQ_SET       = 16'h800C;
    localparam logic [15:0] IRQ_ACK       = 16'hC004;
    localparam logic [15:0] IRQ_ENABLE    = 16'hC008;
    localparam logic [15:0] IRQ_STOP      = 16'hC00C;

    localparam logic [6:0] LINES_PER_IRQ = 7'd84;
    localparam logic [7:0] BANK_FIXED_LO = 8'd254;
    localparam logic [7:0] BANK_FIXED_HI = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic       irq_line;
        logic [1:0] mirror_mode;
        logic [7:0] bank;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/core/cbm_state.sv
// Mapper registers, write decoders, line counter and bank lookup.
`default_nettype none
module cbm_state (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  cbm_pkg::t_in_item   i_item,
    output cbm_pkg::t_out_item  o_result
);

    logic [7:0] r_prg [2];
    logic [7:0] r_chr [8];
    logic       r_mirror_sel;
    logic [1:0] r_one_screen;
    logic [6:0] r_line_count;
    logic       r_count_en;
    logic       r_irq;
    logic       r_prev_a13;

    logic [7:0] n_prg [2];
    logic [7:0] n_chr [8];
    logic       n_mirror_sel;
    logic [1:0] n_one_screen;
    logic [6:0] n_line_count;
    logic       n_count_en;
    logic       n_irq;
    logic       n_prev_a13;

    logic [1:0] w_chr_nib;
    logic [2:0] w_chr_idx;
    logic [6:0] w_count_inc;
    logic [7:0] w_bank;

    assign w_chr_nib   = i_item.address[13:12] - cbm_pkg::CHR_BASE_NIB[1:0];
    assign w_chr_idx   = {w_chr_nib, i_item.address[1]};
    assign w_count_inc = r_line_count + 7'd1;

    always_comb begin
        n_prg        = r_prg;
        n_chr        = r_chr;
        n_mirror_sel = r_mirror_sel;
        n_one_screen = r_one_screen;
        n_line_count = r_line_count;
        n_count_en   = r_count_en;
        n_irq        = r_irq;
        n_prev_a13   = r_prev_a13;
        w_bank       = 8'd0;
        case (i_item.opcode)
            cbm_pkg::OP_CPU_WRITE: begin
                case (i_item.address & cbm_pkg::WR_DEC_MASK)
                    cbm_pkg::WR_PRG0:   n_prg[0] = i_item.data;
                    cbm_pkg::WR_MIRROR: n_mirror_sel = i_item.data[0];
                    cbm_pkg::WR_PRG1:   n_prg[1] = i_item.data;
                    cbm_pkg::WR_CHR_B, cbm_pkg::WR_CHR_C,
                    cbm_pkg::WR_CHR_D, cbm_pkg::WR_CHR_E: begin
                        if (i_item.address[0]) begin
                            n_chr[w_chr_idx][7:4] = i_item.data[3:0];
                        end else begin
                            n_chr[w_chr_idx][3:0] = i_item.data[3:0];
                        end
                    end
                    default: ;
                endcase
                case (i_item.address & cbm_pkg::IRQ_DEC_MASK)
                    cbm_pkg::IRQ_ONESCREEN: n_one_screen = i_item.data[1:0];
                    cbm_pkg::IRQ_SET:       n_irq = 1'b1;
                    cbm_pkg::IRQ_ACK:       n_irq = 1'b0;
                    cbm_pkg::IRQ_ENABLE:    n_count_en = 1'b1;
                    cbm_pkg::IRQ_STOP: begin
                        n_count_en   = 1'b0;
                        n_line_count = 7'd0;
                        n_irq        = 1'b0;
                    end
                    default: ;
                endcase
            end
            cbm_pkg::OP_PPU_ADDR: begin
                // falling edge of A13 counts one line while counting is enabled
                if (r_prev_a13 && !i_item.address[13] && r_count_en) begin
                    if (w_count_inc == cbm_pkg::LINES_PER_IRQ) begin
                        n_line_count = 7'd0;
                        n_irq        = 1'b1;
                    end else begin
                        n_line_count = w_count_inc;
                    end
                end
                n_prev_a13 = i_item.address[13];
                if (i_item.address[15:13] == 3'd0) begin
                    w_bank = r_chr[i_item.address[12:10]];
                end
            end
            cbm_pkg::OP_CPU_READ: begin
                if (i_item.address[15]) begin
                    case (i_item.address[14:13])
                        2'd0:    w_bank = r_prg[0];
                        2'd1:    w_bank = r_prg[1];
                        2'd2:    w_bank = cbm_pkg::BANK_FIXED_LO;
                        default: w_bank = cbm_pkg::BANK_FIXED_HI;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.irq_line = n_irq;
        o_result.bank     = w_bank;
        if (n_one_screen[1]) begin
            o_result.mirror_mode = {1'b1, n_one_screen[0]};
        end else begin
            o_result.mirror_mode = {1'b0, ~n_mirror_sel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg        <= '{default: 8'd0};
            r_chr        <= '{default: 8'd0};
            r_mirror_sel <= 1'b0;
            r_one_screen <= 2'd0;
            r_line_count <= 7'd0;
            r_count_en   <= 1'b0;
            r_irq        <= 1'b0;
            r_prev_a13   <= 1'b0;
        end else if (i_fire) begin
            r_prg        <= n_prg;
            r_chr        <= n_chr;
            r_mirror_sel <= n_mirror_sel;
            r_one_screen <= n_one_screen;
            r_line_count <= n_line_count;
            r_count_en   <= n_count_en;
            r_irq        <= n_irq;
            r_prev_a13   <= n_prev_a13;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cartridge_bank_mapper_with_line_irq.sv
// Cartridge bank mapper top level: input register, mapper state, result register.
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle if not stalled, set by a single mapper-state pass.
// A full input register stalls while output backpressure holds the result register.
// Reset: synchronous active low; clears all bank, mirroring and interrupt state
// and empties both registers.
`default_nettype none
module cartridge_bank_mapper_with_line_irq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  cbm_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cbm_pkg::t_out_item  o_out_item
);

    logic                r_s1_valid;
    cbm_pkg::t_in_item   r_s1_item;
    logic                r_out_valid;
    cbm_pkg::t_out_item  r_out_item;

    logic                w_out_free;
    logic                w_s1_adv;
    cbm_pkg::t_out_item  w_result;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_adv    = r_s1_valid && w_out_free;
    assign o_in_ready  = !r_s1_valid || w_s1_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    cbm_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_s1_adv),
        .i_item   (r_s1_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_s1_item <= i_in_item;
        end
        if (w_s1_adv) begin
            r_out_item <= w_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> o_out_valid)
        else $error("advanced item did not reach result register");

    a_low_read_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_item.opcode == cbm_pkg::OP_CPU_READ && !r_s1_item.address[15])
        |=> (o_out_item.bank == 8'd0))
        else $error("CPU read below program space returned nonzero bank");

    a_stop_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_item.opcode == cbm_pkg::OP_CPU_WRITE
            && (r_s1_item.address & cbm_pkg::IRQ_DEC_MASK) == cbm_pkg::IRQ_STOP)
        |=> !o_out_item.irq_line)
        else $error("counter stop write left interrupt asserted");
`endif

endmodule
`default_nettype wire
